// File: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define CHK_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/pidpd_pkg.sv
package pidpd_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int GAIN_W    = 16;
    localparam int GAIN_FRAC = 8;
    localparam int LIMIT_W   = 16;
    localparam int INT_W     = 16;

    localparam int ERR_W   = SAMPLE_W + 1;
    localparam int DIFF1_W = ERR_W + 1;
    localparam int DIFF2_W = ERR_W + 2;

    localparam int PROD_P_W = GAIN_W + DIFF1_W;
    localparam int PROD_I_W = GAIN_W + ERR_W;
    localparam int PROD_D_W = GAIN_W + DIFF2_W;

    localparam int TERM_P_W = PROD_P_W - GAIN_FRAC;
    localparam int TERM_I_W = PROD_I_W - GAIN_FRAC;
    localparam int TERM_D_W = PROD_D_W - GAIN_FRAC;
    localparam int SUM_W    = TERM_D_W + 3;

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    localparam logic signed [LIMIT_W-1:0] UPPER_RESET = 16'sh7FFF;
    localparam logic signed [LIMIT_W-1:0] LOWER_RESET = 16'sh8000;

    typedef enum logic [2:0] {
        REG_LOOP_MODE   = 3'd0,
        REG_GAIN_P      = 3'd1,
        REG_GAIN_I      = 3'd2,
        REG_GAIN_D      = 3'd3,
        REG_DEAD_ZONE   = 3'd4,
        REG_UPPER_LIMIT = 3'd5,
        REG_LOWER_LIMIT = 3'd6
    } pidpd_reg_t;

    typedef enum logic {
        MODE_POSITIONAL = 1'b0,
        MODE_DELTA      = 1'b1
    } pidpd_mode_t;

    typedef struct packed {
        pidpd_mode_t               loop_mode;
        logic [GAIN_W-1:0]         gain_p;
        logic [GAIN_W-1:0]         gain_i;
        logic [GAIN_W-1:0]         gain_d;
        logic [SAMPLE_W-1:0]       dead_zone;
        logic [LIMIT_W-1:0]        upper_limit;
        logic [LIMIT_W-1:0]        lower_limit;
    } pidpd_cfg_t;

endpackage

// File: rtl/core/pid_controller_pos_delta.sv
// PID controller, positional or incremental (delta) form, Q8.8 gains.
// Request channel: in_valid / in_stall with setpoint and feedback. A request
// is taken at a rising edge where in_valid is high and in_stall is low.
// Result channel: out_valid / out_stall with drive, one result per request,
// in request order. The result is taken where out_valid is high and
// out_stall is low.
// From acceptance to out_valid a request passes one input register, then the
// error, three parallel gain multiplies, the sums and the limit clamps in one
// combinational pass into the output register.
// Throughput is one request per cycle while out_stall is low. The controller
// state (error history, integral, held drive) updates as a request moves into
// the output register, so the next request sees it without a bubble.
// When the receiver stalls, the output holds and one more request can wait in
// the input register; in_stall rises only while both registers are full.
// Reset clears the pipeline, the error history, the integral and the held
// drive, and loads the register defaults (positional mode, zero gains and
// deadband, full-scale limits). Configure over APB only while idle.
module pid_controller_pos_delta (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [pidpd_pkg::SAMPLE_W-1:0] setpoint,
    input  logic signed [pidpd_pkg::SAMPLE_W-1:0] feedback,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [pidpd_pkg::SAMPLE_W-1:0] drive,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [pidpd_pkg::APB_AW-1:0]          paddr,
    input  logic [pidpd_pkg::APB_DW-1:0]          pwdata,
    output logic [pidpd_pkg::APB_DW-1:0]          prdata,
    output logic                                  pready
);
    import pidpd_pkg::*;

    pidpd_cfg_t                 cfg;
    logic                       in_valid_reg, in_valid_next;
    logic signed [SAMPLE_W-1:0] setpoint_reg;
    logic signed [SAMPLE_W-1:0] feedback_reg;
    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] drive_reg;
    logic signed [SAMPLE_W-1:0] drive_calc;
    logic                       out_free;
    logic                       take;
    logic                       step;

    pidpd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pidpd_law u_law (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .cfg      (cfg),
        .setpoint (setpoint_reg),
        .feedback (feedback_reg),
        .drive    (drive_calc)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign step     = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign take     = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (step)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            setpoint_reg <= setpoint;
            feedback_reg <= feedback;
        end
        if (step)
            drive_reg <= drive_calc;
    end

endmodule

// File: rtl/core/pidpd_regs.sv
module pidpd_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pidpd_pkg::APB_AW-1:0]  paddr,
    input  logic [pidpd_pkg::APB_DW-1:0]  pwdata,
    output logic [pidpd_pkg::APB_DW-1:0]  prdata,
    output logic                          pready,
    output pidpd_pkg::pidpd_cfg_t         cfg
);
    import pidpd_pkg::*;

    pidpd_cfg_t cfg_reg;
    pidpd_cfg_t cfg_next;
    pidpd_reg_t reg_sel;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_sel = pidpd_reg_t'(paddr[APB_AW-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                REG_LOOP_MODE:   cfg_next.loop_mode   = pidpd_mode_t'(pwdata[0]);
                REG_GAIN_P:      cfg_next.gain_p      = pwdata[GAIN_W-1:0];
                REG_GAIN_I:      cfg_next.gain_i      = pwdata[GAIN_W-1:0];
                REG_GAIN_D:      cfg_next.gain_d      = pwdata[GAIN_W-1:0];
                REG_DEAD_ZONE:   cfg_next.dead_zone   = pwdata[SAMPLE_W-1:0];
                REG_UPPER_LIMIT: cfg_next.upper_limit = pwdata[LIMIT_W-1:0];
                REG_LOWER_LIMIT: cfg_next.lower_limit = pwdata[LIMIT_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_LOOP_MODE:   prdata = APB_DW'(cfg_reg.loop_mode);
            REG_GAIN_P:      prdata = APB_DW'(cfg_reg.gain_p);
            REG_GAIN_I:      prdata = APB_DW'(cfg_reg.gain_i);
            REG_GAIN_D:      prdata = APB_DW'(cfg_reg.gain_d);
            REG_DEAD_ZONE:   prdata = APB_DW'(cfg_reg.dead_zone);
            REG_UPPER_LIMIT: prdata = APB_DW'(cfg_reg.upper_limit);
            REG_LOWER_LIMIT: prdata = APB_DW'(cfg_reg.lower_limit);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.loop_mode   <= MODE_POSITIONAL;
            cfg_reg.gain_p      <= '0;
            cfg_reg.gain_i      <= '0;
            cfg_reg.gain_d      <= '0;
            cfg_reg.dead_zone   <= '0;
            cfg_reg.upper_limit <= UPPER_RESET;
            cfg_reg.lower_limit <= LOWER_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: rtl/core/pidpd_law.sv
module pidpd_law (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step,
    input  pidpd_pkg::pidpd_cfg_t               cfg,
    input  logic signed [pidpd_pkg::SAMPLE_W-1:0] setpoint,
    input  logic signed [pidpd_pkg::SAMPLE_W-1:0] feedback,
    output logic signed [pidpd_pkg::SAMPLE_W-1:0] drive
);
    import pidpd_pkg::*;

    logic signed [ERR_W-1:0]    error_now_reg, error_now_next;
    logic signed [ERR_W-1:0]    error_prev_reg, error_prev_next;
    logic signed [INT_W-1:0]    integral_reg, integral_next;
    logic signed [SAMPLE_W-1:0] held_reg, held_next;

    logic signed [GAIN_W-1:0]   gain_p, gain_i, gain_d;
    logic signed [LIMIT_W-1:0]  upper, lower;
    logic signed [ERR_W-1:0]    err;
    logic [ERR_W-1:0]           mag;
    logic                       active;
    logic signed [DIFF1_W-1:0]  diff1;
    logic signed [DIFF2_W-1:0]  diff2;
    logic signed [DIFF1_W-1:0]  op_p;
    logic signed [DIFF2_W-1:0]  op_d;
    logic signed [PROD_P_W-1:0] prod_p;
    logic signed [PROD_I_W-1:0] prod_i;
    logic signed [PROD_D_W-1:0] prod_d;
    logic signed [TERM_P_W-1:0] term_p;
    logic signed [TERM_I_W-1:0] term_i;
    logic signed [TERM_D_W-1:0] term_d;
    logic signed [SUM_W-1:0]    integ_sum;
    logic signed [INT_W-1:0]    integ_clamped;
    logic signed [INT_W-1:0]    integ_sat;
    logic signed [TERM_I_W-1:0] i_sel;
    logic signed [SUM_W-1:0]    total;
    logic signed [SAMPLE_W-1:0] drive_new;

    // min against the ceiling, then max against the floor: crossed limits give the floor
    function automatic logic signed [LIMIT_W-1:0] clamp_lim(
        input logic signed [SUM_W-1:0]   x,
        input logic signed [LIMIT_W-1:0] hi,
        input logic signed [LIMIT_W-1:0] lo
    );
        logic signed [SUM_W-1:0] t;
        begin
            t = x;
            if (t > SUM_W'(hi))
                t = SUM_W'(hi);
            if (t < SUM_W'(lo))
                t = SUM_W'(lo);
            clamp_lim = t[LIMIT_W-1:0];
        end
    endfunction

    assign gain_p = $signed(cfg.gain_p);
    assign gain_i = $signed(cfg.gain_i);
    assign gain_d = $signed(cfg.gain_d);
    assign upper  = $signed(cfg.upper_limit);
    assign lower  = $signed(cfg.lower_limit);

    assign err    = ERR_W'(setpoint) - ERR_W'(feedback);
    assign mag    = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
    assign active = mag > {1'b0, cfg.dead_zone};

    assign diff1 = DIFF1_W'(err) - DIFF1_W'(error_now_reg);
    assign diff2 = DIFF2_W'(err) - (DIFF2_W'(error_now_reg) <<< 1) + DIFF2_W'(error_prev_reg);

    // share one multiplier per term between the two modes
    assign op_p = (cfg.loop_mode == MODE_DELTA) ? diff1 : DIFF1_W'(err);
    assign op_d = (cfg.loop_mode == MODE_DELTA) ? diff2 : DIFF2_W'(diff1);

    assign prod_p = PROD_P_W'(gain_p) * PROD_P_W'(op_p);
    assign prod_i = PROD_I_W'(gain_i) * PROD_I_W'(err);
    assign prod_d = PROD_D_W'(gain_d) * PROD_D_W'(op_d);

    // drop the fraction bits: arithmetic shift, rounds toward minus infinity
    assign term_p = prod_p[PROD_P_W-1:GAIN_FRAC];
    assign term_i = prod_i[PROD_I_W-1:GAIN_FRAC];
    assign term_d = prod_d[PROD_D_W-1:GAIN_FRAC];

    assign integ_sum     = SUM_W'(integral_reg) + SUM_W'(term_i);
    assign integ_clamped = clamp_lim(integ_sum, upper, lower);

    always_comb
    begin
        if (term_i > TERM_I_W'(16'sh7FFF))
            integ_sat = 16'sh7FFF;
        else if (term_i < TERM_I_W'(16'sh8000))
            integ_sat = 16'sh8000;
        else
            integ_sat = term_i[INT_W-1:0];
    end

    assign i_sel = (cfg.loop_mode == MODE_DELTA) ? term_i : TERM_I_W'(integ_clamped);
    assign total = SUM_W'(term_p) + SUM_W'(i_sel) + SUM_W'(term_d);
    assign drive_new = clamp_lim(total, upper, lower);

    always_comb
    begin
        error_now_next  = error_now_reg;
        error_prev_next = error_prev_reg;
        integral_next   = integral_reg;
        held_next       = held_reg;
        if (step)
        begin
            error_prev_next = error_now_reg;
            error_now_next  = err;
            if (active)
            begin
                integral_next = (cfg.loop_mode == MODE_DELTA) ? integ_sat : integ_clamped;
                held_next     = drive_new;
            end
        end
    end

    assign drive = active ? drive_new : held_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_now_reg  <= '0;
            error_prev_reg <= '0;
            integral_reg   <= '0;
            held_reg       <= '0;
        end
        else
        begin
            error_now_reg  <= error_now_next;
            error_prev_reg <= error_prev_next;
            integral_reg   <= integral_next;
            held_reg       <= held_next;
        end
    end

endmodule

// File: rtl/core/pidpd_checker.sv
`include "assert_macros.svh"

module pidpd_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_valid,
    input logic                                  in_stall,
    input logic                                  out_valid,
    input logic                                  out_stall,
    input logic signed [pidpd_pkg::SAMPLE_W-1:0] drive
);
    import pidpd_pkg::*;

    // hold a stalled result
    `CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(drive), "stalled result changed")

    // back-pressure only when both the input and output registers are full
    `CHK_IMPLY(a_stall_cause, in_stall, out_valid && out_stall, "input stalled with output free")

    // a fresh result follows a request taken earlier through the input and output registers
    `CHK_IMPLY(a_no_phantom, $rose(out_valid), $past(in_valid && !in_stall, 2), "result without request")

    // a request taken while the output register is empty is followed by out_valid once it has passed the input register
    `CHK_NEXT(a_latency, in_valid && !in_stall && !out_valid && !in_stall, ##1 out_valid, "result late")

endmodule

bind pid_controller_pos_delta pidpd_checker u_pidpd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .drive     (drive)
);

// File: bench/pid_drive_scoreboard_pkg.sv
package pid_drive_scoreboard_pkg;

    import pidpd_pkg::*;

    class pid_drive_scoreboard;

        pidpd_mode_t mode;
        longint      gain_p;
        longint      gain_i;
        longint      gain_d;
        longint      dead_zone;
        longint      upper_limit;
        longint      lower_limit;

        longint      err_now;
        longint      err_prev;
        longint      integral;
        longint      held_drive;

        logic signed [SAMPLE_W-1:0] drive_q[$];
        int                         errors;

        function new();
            mode        = MODE_POSITIONAL;
            gain_p      = 0;
            gain_i      = 0;
            gain_d      = 0;
            dead_zone   = 0;
            upper_limit = 32767;
            lower_limit = -32768;
            err_now     = 0;
            err_prev    = 0;
            integral    = 0;
            held_drive  = 0;
            errors      = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [15:0] val);
            case (idx)
                REG_LOOP_MODE:   mode        = pidpd_mode_t'(val[0]);
                REG_GAIN_P:      gain_p      = longint'($signed(val));
                REG_GAIN_I:      gain_i      = longint'($signed(val));
                REG_GAIN_D:      gain_d      = longint'($signed(val));
                REG_DEAD_ZONE:   dead_zone   = longint'(val);
                REG_UPPER_LIMIT: upper_limit = longint'($signed(val));
                REG_LOWER_LIMIT: lower_limit = longint'($signed(val));
                default:         ;
            endcase
        endfunction

        // ceiling first, then floor: the floor wins when the limits cross
        function longint clamp_limits(longint x);
            if (x > upper_limit)
                x = upper_limit;
            if (x < lower_limit)
                x = lower_limit;
            return x;
        endfunction

        function longint sat16(longint x);
            if (x > 32767)
                return 32767;
            if (x < -32768)
                return -32768;
            return x;
        endfunction

        function void note_request(logic signed [SAMPLE_W-1:0] sp,
                                   logic signed [SAMPLE_W-1:0] fb);
            longint e;
            longint e1;
            longint e2;
            longint mag;
            longint p;
            longint i;
            longint d;
            e2  = err_prev;
            e1  = err_now;
            e   = longint'(sp) - longint'(fb);
            mag = (e < 0) ? -e : e;
            err_prev = e1;
            err_now  = e;
            if (mag > dead_zone) begin
                if (mode == MODE_POSITIONAL) begin
                    p        = (gain_p * e) >>> GAIN_FRAC;
                    integral = clamp_limits(integral + ((gain_i * e) >>> GAIN_FRAC));
                    i        = integral;
                    d        = (gain_d * (e - e1)) >>> GAIN_FRAC;
                end
                else begin
                    p        = (gain_p * (e - e1)) >>> GAIN_FRAC;
                    i        = (gain_i * e) >>> GAIN_FRAC;
                    d        = (gain_d * (e - 2 * e1 + e2)) >>> GAIN_FRAC;
                    integral = sat16(i);
                end
                held_drive = sat16(clamp_limits(p + i + d));
            end
            drive_q.push_back(16'(held_drive));
        endfunction

        function void check_drive(logic signed [SAMPLE_W-1:0] actual);
            logic signed [SAMPLE_W-1:0] want;
            if (drive_q.size() == 0) begin
                $error("drive: no result expected, actual %0d", actual);
                errors++;
                return;
            end
            want = drive_q.pop_front();
            if (actual !== want) begin
                $error("drive mismatch: expected %0d, actual %0d", want, actual);
                errors++;
            end
        endfunction

        function int pending();
            return drive_q.size();
        endfunction

    endclass

endpackage

// File: bench/tb_pid_controller_pos_delta.sv
module tb_pid_controller_pos_delta;

    import pidpd_pkg::*;
    import pid_drive_scoreboard_pkg::*;

    localparam int         CYCLE_LIMIT = 400000;
    localparam int         PHASES      = 14;
    localparam int         PHASE_LEN   = 100;
    localparam logic [2:0] REG_SPARE   = 3'd7;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] setpoint;
    logic signed [SAMPLE_W-1:0] feedback;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [SAMPLE_W-1:0] drive;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [APB_AW-1:0]          paddr;
    logic [APB_DW-1:0]          pwdata;
    logic [APB_DW-1:0]          prdata;
    logic                       pready;

    int unsigned         cycle_count = 0;
    bit                  no_idle     = 1'b0;
    pid_drive_scoreboard drive_sb;

    pid_controller_pos_delta u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .setpoint  (setpoint),
        .feedback  (feedback),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .drive     (drive),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    // setup cycle, access cycle, then the bus idles before the task returns
    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0000, val};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        drive_sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic send_sample(logic signed [SAMPLE_W-1:0] sp,
                               logic signed [SAMPLE_W-1:0] fb);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        // keep valid high across back-to-back requests
        in_valid <= 1'b1;
        setpoint <= sp;
        feedback <= fb;
        do @(posedge clk); while (in_stall);
        drive_sb.note_request(sp, fb);
    endtask

    // hold off until every outstanding drive result is back
    task automatic drain();
        in_valid <= 1'b0;
        while (drive_sb.pending() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(0, 1023)) - 16'd512;
            1:       return 16'($urandom_range(0, 127)) - 16'd64;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_extreme();
        case ($urandom_range(0, 3))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            default: return 16'shFFFF;
        endcase
    endfunction

    task automatic random_config();
        int unsigned                kind;
        logic signed [LIMIT_W-1:0]  lim_a;
        logic signed [LIMIT_W-1:0]  lim_b;
        logic signed [LIMIT_W-1:0]  swap;
        write_reg(REG_LOOP_MODE, 16'($urandom_range(0, 1)));
        write_reg(REG_GAIN_P, pick_gain());
        write_reg(REG_GAIN_I, pick_gain());
        write_reg(REG_GAIN_D, pick_gain());
        kind = $urandom_range(0, 19);
        if (kind < 10)
            write_reg(REG_DEAD_ZONE, 16'h0000);
        else if (kind < 17)
            write_reg(REG_DEAD_ZONE, 16'($urandom_range(0, 300)));
        else
            write_reg(REG_DEAD_ZONE, 16'($urandom));
        kind  = $urandom_range(0, 9);
        lim_a = 16'($urandom);
        lim_b = 16'($urandom);
        if (kind < 6)
        begin
            lim_a = LOWER_RESET;
            lim_b = UPPER_RESET;
        end
        else if (kind < 9 && lim_a > lim_b)
        begin
            swap  = lim_a;
            lim_a = lim_b;
            lim_b = swap;
        end
        write_reg(REG_LOWER_LIMIT, lim_a);
        write_reg(REG_UPPER_LIMIT, lim_b);
    endtask

    task automatic random_sample(output logic signed [SAMPLE_W-1:0] sp,
                                 output logic signed [SAMPLE_W-1:0] fb);
        int unsigned kind;
        kind = $urandom_range(0, 9);
        sp   = 16'($urandom);
        fb   = 16'($urandom);
        if (kind >= 5 && kind <= 7)
            fb = sp + 16'($urandom_range(0, 600)) - 16'd300;
        else if (kind == 8)
        begin
            sp = pick_extreme();
            fb = pick_extreme();
        end
        else if (kind == 9)
            fb = sp;
    endtask

    // result side: random stall before each result, none in fast phases
    initial
    begin : result_sink
        int unsigned hold;
        wait (rst_n === 1'b1);
        forever
        begin
            hold = no_idle ? 0 : $urandom_range(0, 12);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            drive_sb.check_drive(drive);
        end
    end

    initial
    begin : stimulus
        logic signed [SAMPLE_W-1:0] sp;
        logic signed [SAMPLE_W-1:0] fb;
        drive_sb  = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        setpoint  = '0;
        feedback  = '0;
        out_stall = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // positional mode, full-scale errors in both directions
        write_reg(REG_LOOP_MODE, 16'(MODE_POSITIONAL));
        write_reg(REG_GAIN_P, 16'h0100);
        write_reg(REG_GAIN_I, 16'h0020);
        write_reg(REG_GAIN_D, 16'h0040);
        write_reg(REG_DEAD_ZONE, 16'h0000);
        write_reg(REG_UPPER_LIMIT, UPPER_RESET);
        write_reg(REG_LOWER_LIMIT, LOWER_RESET);
        write_reg(REG_SPARE, 16'h1234);
        send_sample(16'sh0000, 16'sh0000);
        send_sample(16'sh7FFF, 16'sh8000);
        send_sample(16'sh8000, 16'sh7FFF);
        send_sample(16'sh7FFF, 16'sh8000);
        send_sample(16'sh0001, 16'sh0000);
        send_sample(16'sh0000, 16'sh0001);
        send_sample(16'shFFFF, 16'shFFFF);
        send_sample(16'sh0064, -16'sh0064);
        drain();

        // deadband: hold inside, update just outside
        write_reg(REG_DEAD_ZONE, 16'h0005);
        send_sample(16'sh0003, 16'sh0000);
        send_sample(16'sh0000, 16'sh0005);
        send_sample(16'sh0000, 16'sh0006);
        drain();

        // delta mode with extreme gains
        write_reg(REG_LOOP_MODE, 16'(MODE_DELTA));
        write_reg(REG_GAIN_P, 16'h7FFF);
        write_reg(REG_GAIN_I, 16'h8000);
        write_reg(REG_GAIN_D, 16'h8000);
        write_reg(REG_DEAD_ZONE, 16'h0000);
        send_sample(16'sh7FFF, 16'sh8000);
        send_sample(16'sh8000, 16'sh7FFF);
        send_sample(16'sh3039, -16'sh07D0);
        send_sample(16'sh0000, 16'sh0000);
        drain();

        // crossed limits: floor wins
        write_reg(REG_UPPER_LIMIT, -16'sh0064);
        write_reg(REG_LOWER_LIMIT, 16'sh0064);
        send_sample(16'sh01F4, 16'sh0000);
        send_sample(-16'sh01F4, 16'sh0000);
        drain();

        // widest deadband holds even the largest error
        write_reg(REG_UPPER_LIMIT, UPPER_RESET);
        write_reg(REG_LOWER_LIMIT, LOWER_RESET);
        write_reg(REG_DEAD_ZONE, 16'hFFFF);
        send_sample(16'sh7FFF, 16'sh8000);
        send_sample(16'sh8000, 16'sh7FFF);
        drain();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            random_config();
            no_idle = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < PHASE_LEN; k++)
            begin
                random_sample(sp, fb);
                send_sample(sp, fb);
            end
            drain();
            no_idle = 1'b0;
        end

        repeat (10) @(posedge clk);
        if (drive_sb.errors == 0 && drive_sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
